FILE: hw/rtl/esu_pkg.sv
// shared constants, command and status types and helper functions for the edge update core
package esu_pkg;

  localparam int FIELD_W       = 32;
  localparam int STR_W         = 17;
  localparam int MAG_W         = 35;
  localparam int RATE_FRAC     = 16;
  localparam int FRAC_MASK     = 65535;
  localparam int ACT_GAIN      = 10;
  localparam int NODE_BITS_DEF = 32;
  localparam int TICK_BITS_DEF = 32;
  localparam int IN_DATA_W     = 96;
  localparam int OUT_DATA_W    = 88;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [STR_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
  localparam logic [OP_W-1:0] OP_PULSE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_ACT = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STR   = 2'd3;

  localparam logic [STR_W-1:0] MATCH_RATE_RST = 17'd328;
  localparam logic [STR_W-1:0] MISS_RATE_RST  = 17'd6554;
  localparam logic [STR_W-1:0] PULSE_RATE_RST = 17'd2621;
  localparam logic [STR_W-1:0] INIT_STR_RST   = 17'd7;

  typedef struct packed {
    logic load_in;
    logic pre_upd;
    logic div_start;
    logic mul_g;
    logic mul_t;
    logic pulse_upd;
    logic out_load;
  } esu_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pulse_go;
  } esu_sts_t;

  function automatic logic [STR_W-1:0] rate_clamp(input logic [STR_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [FIELD_W-1:0] res;
    if (v[63:FIELD_W-1] == '0 || v[63:FIELD_W-1] == '1) begin
      res = v[FIELD_W-1:0];
    end else if (v[63]) begin
      res = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/esu_div.sv
// restoring divider: two signed numerators over one shared unsigned age, one bit per cycle
module esu_div import esu_pkg::*; #(
  parameter int AGE_W = TICK_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [FIELD_W-1:0] num_a,
  input  logic signed [MAG_W:0]     num_b,
  input  logic [AGE_W-1:0]          age,
  output logic                     done,
  output logic signed [MAG_W:0]     quo_a,
  output logic signed [MAG_W:0]     quo_b
);

  localparam int CNT_W = $clog2(MAG_W);

  logic [AGE_W-1:0]       divisor;
  logic [AGE_W-1:0]       rem_a;
  logic [AGE_W-1:0]       rem_b;
  logic [MAG_W-1:0]       sh_a;
  logic [MAG_W-1:0]       sh_b;
  logic                   neg_a;
  logic                   neg_b;
  logic                   busy;
  logic [CNT_W-1:0]       cnt;

  logic signed [MAG_W:0]  ext_a;
  logic [MAG_W:0]         abs_a;
  logic [MAG_W:0]         abs_b;
  logic [AGE_W:0]         trial_a;
  logic [AGE_W:0]         trial_b;
  logic [AGE_W:0]         diff_a;
  logic [AGE_W:0]         diff_b;
  logic                   ge_a;
  logic                   ge_b;

  assign ext_a   = (MAG_W+1)'(num_a);
  assign abs_a   = ext_a[MAG_W] ? -ext_a : ext_a;
  assign abs_b   = num_b[MAG_W] ? -num_b : num_b;

  assign trial_a = {rem_a, sh_a[MAG_W-1]};
  assign trial_b = {rem_b, sh_b[MAG_W-1]};
  assign diff_a  = trial_a - {1'b0, divisor};
  assign diff_b  = trial_b - {1'b0, divisor};
  assign ge_a    = trial_a >= {1'b0, divisor};
  assign ge_b    = trial_b >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == (CNT_W)'(MAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= age;
      rem_a   <= '0;
      rem_b   <= '0;
      sh_a    <= abs_a[MAG_W-1:0];
      sh_b    <= abs_b[MAG_W-1:0];
      neg_a   <= ext_a[MAG_W];
      neg_b   <= num_b[MAG_W];
    end else if (busy) begin
      rem_a <= ge_a ? diff_a[AGE_W-1:0] : trial_a[AGE_W-1:0];
      rem_b <= ge_b ? diff_b[AGE_W-1:0] : trial_b[AGE_W-1:0];
      sh_a  <= {sh_a[MAG_W-2:0], ge_a};
      sh_b  <= {sh_b[MAG_W-2:0], ge_b};
    end
  end

  assign quo_a = neg_a ? -$signed({1'b0, sh_a}) : $signed({1'b0, sh_a});
  assign quo_b = neg_b ? -$signed({1'b0, sh_b}) : $signed({1'b0, sh_b});

endmodule

FILE: hw/rtl/esu_datapath.sv
// datapath: settings, edge state, strength and change arithmetic, divider and result register
module esu_datapath import esu_pkg::*; #(
  parameter int NODE_BITS = NODE_BITS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  esu_cmd_t              cmd,
  output esu_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [OP_W-1:0]       in_op,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STR_W-1:0]      cfg_wdata,
  output logic                  out_accepted,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int NODE_W = (NODE_BITS < FIELD_W) ? NODE_BITS : FIELD_W;
  localparam int TICK_W = (TICK_BITS < FIELD_W) ? TICK_BITS : FIELD_W;
  localparam int AGE_W  = TICK_BITS + 1;
  localparam int GP_W   = FIELD_W + STR_W + 1;
  localparam int TP_W   = 2 * FIELD_W + 1;
  localparam int TS_W   = TP_W - RATE_FRAC;
  localparam int PAD_W  = OUT_DATA_W - STR_W - 2 * FIELD_W;

  // captured input beat
  logic [OP_W-1:0]           op_r;
  logic [NODE_W-1:0]         node_r;
  logic signed [FIELD_W-1:0] sig_r;
  logic [TICK_W-1:0]         tick_r;

  // settings
  logic [STR_W-1:0]          rate_match;
  logic [STR_W-1:0]          rate_miss;
  logic [STR_W-1:0]          rate_pulse;
  logic [STR_W-1:0]          init_str;

  // edge state
  logic [NODE_W-1:0]         head_node;
  logic [STR_W-1:0]          edge_strength;
  logic signed [FIELD_W-1:0] change_level;
  logic signed [FIELD_W-1:0] activation_level;
  logic [TICK_W-1:0]         last_tick;

  logic                      acc_r;
  logic                      pulse_go;
  logic signed [FIELD_W-1:0] g_r;
  logic signed [TP_W-1:0]    tprod;

  logic                      head_match;
  logic                      tick_new;
  logic [STR_W-1:0]          smul_a;
  logic [STR_W-1:0]          smul_b;
  logic [2*STR_W-1:0]        sprod;
  logic [STR_W-1:0]          sdelta;
  logic [STR_W-1:0]          str_up;
  logic [STR_W-1:0]          str_dn;
  logic signed [FIELD_W:0]   dv;
  logic signed [FIELD_W:0]   dv_abs;
  logic signed [FIELD_W-1:0] cl_set;
  logic signed [MAG_W:0]     act10;
  logic [TICK_BITS-1:0]      tick_ext;
  logic [TICK_BITS-1:0]      last_ext;
  logic [TICK_BITS-1:0]      tick_diff;
  logic [AGE_W-1:0]          age;
  logic                      div_done;
  logic signed [MAG_W:0]     quo_a;
  logic signed [MAG_W:0]     quo_b;
  logic signed [FIELD_W:0]   d_val;
  logic signed [FIELD_W:0]   one_minus_d;
  logic signed [GP_W-1:0]    gprod;
  logic [GP_W-1:0]           gbias;
  logic [TP_W-1:0]           tbias;
  logic signed [TS_W-1:0]    term;
  logic signed [FIELD_W-1:0] cl_pulse;
  logic signed [FIELD_W-1:0] sig_out;
  logic signed [FIELD_W-1:0] dec_out;

  assign head_match = node_r == head_node;
  assign tick_new   = tick_r != last_tick;

  // strength update: one shared 17x17 multiplier
  always_comb begin
    if (cmd.pulse_upd) begin
      smul_a = ONE_Q16 - edge_strength;
      smul_b = rate_clamp(rate_pulse);
    end else if (head_match) begin
      smul_a = ONE_Q16 - edge_strength;
      smul_b = rate_clamp(rate_match);
    end else begin
      smul_a = edge_strength;
      smul_b = rate_clamp(rate_miss);
    end
  end

  assign sprod  = smul_a * smul_b;
  assign sdelta = sprod[RATE_FRAC +: STR_W];
  assign str_up = edge_strength + sdelta;
  assign str_dn = edge_strength - sdelta;

  // absolute activation change
  assign dv     = (FIELD_W+1)'(sig_r) - (FIELD_W+1)'(activation_level);
  assign dv_abs = dv[FIELD_W] ? -dv : dv;
  assign cl_set = sat32(64'(dv_abs));

  assign act10  = (MAG_W+1)'(activation_level) * (MAG_W+1)'(ACT_GAIN);

  // age = wrapped tick distance plus one
  assign tick_ext  = TICK_BITS'(tick_r);
  assign last_ext  = TICK_BITS'(last_tick);
  assign tick_diff = tick_ext - last_ext;
  assign age       = AGE_W'(tick_diff) + AGE_W'(1);

  esu_div #(
    .AGE_W (AGE_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_a (change_level),
    .num_b (act10),
    .age   (age),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  assign sts.div_done = div_done;
  assign sts.pulse_go = pulse_go;

  // pulse change update
  assign d_val       = quo_a[FIELD_W:0];
  assign one_minus_d = $signed((FIELD_W+1)'(ONE_Q16)) - d_val;
  assign gprod       = sig_r * $signed({1'b0, edge_strength});
  assign gbias       = gprod + (GP_W)'(gprod[GP_W-1] ? FRAC_MASK : 0);
  assign tbias       = tprod + (TP_W)'(tprod[TP_W-1] ? FRAC_MASK : 0);
  assign term        = tbias[TP_W-1:RATE_FRAC];
  assign cl_pulse    = sat32(64'(d_val) + 64'(term));

  assign sig_out = pulse_go ? change_level : sat32(64'(quo_a));
  assign dec_out = pulse_go ? sat32(64'(act10)) : sat32(64'(quo_b));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      node_r <= in_data[NODE_W-1:0];
      sig_r  <= in_data[2*FIELD_W-1:FIELD_W];
      tick_r <= in_data[2*FIELD_W +: TICK_W];
    end
    if (cmd.mul_g) begin
      g_r <= gbias[RATE_FRAC +: FIELD_W];
    end
    if (cmd.mul_t) begin
      tprod <= one_minus_d * g_r;
    end
    if (cmd.out_load) begin
      out_accepted <= acc_r;
      out_data     <= {PAD_W'(0), dec_out, sig_out, edge_strength};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_match <= MATCH_RATE_RST;
      rate_miss  <= MISS_RATE_RST;
      rate_pulse <= PULSE_RATE_RST;
      init_str   <= INIT_STR_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MATCH_RATE: rate_match <= cfg_wdata;
        CFG_MISS_RATE:  rate_miss  <= cfg_wdata;
        CFG_PULSE_RATE: rate_pulse <= cfg_wdata;
        CFG_INIT_STR:   init_str   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_node        <= '0;
      edge_strength    <= rate_clamp(INIT_STR_RST);
      change_level     <= '0;
      activation_level <= '0;
      last_tick        <= '0;
      acc_r            <= 1'b0;
      pulse_go         <= 1'b0;
    end else if (cmd.pre_upd) begin
      acc_r    <= (op_r == OP_QUERY && head_match) || (op_r == OP_PULSE && tick_new);
      pulse_go <= op_r == OP_PULSE && tick_new;
      case (op_r)
        OP_QUERY: begin
          if (head_match) begin
            edge_strength <= str_up;
          end else begin
            edge_strength <= str_dn;
            head_node     <= node_r;
          end
        end
        OP_PULSE: ;
        OP_SET_ACT: begin
          change_level     <= cl_set;
          activation_level <= sig_r;
          last_tick        <= tick_r;
        end
        OP_CLEAR: begin
          head_node        <= '0;
          edge_strength    <= rate_clamp(init_str);
          change_level     <= '0;
          activation_level <= '0;
          last_tick        <= '0;
        end
        default: ;
      endcase
    end else if (cmd.pulse_upd) begin
      change_level  <= cl_pulse;
      edge_strength <= str_up;
      last_tick     <= tick_r;
    end
  end

endmodule

FILE: hw/rtl/esu_ctrl.sv
// controller: sequences capture, state update, division, pulse multiplies and result beat
module esu_ctrl import esu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  esu_sts_t sts,
  output esu_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRE    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MULG   = 3'd4;
  localparam logic [2:0] S_MULT   = 3'd5;
  localparam logic [2:0] S_UPD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid;

  assign in_ready  = state == S_IDLE;
  assign out_valid = result_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load_in = 1'b1;
        state_next  = S_PRE;
      end
      S_PRE: begin
        cmd.pre_upd = 1'b1;
        state_next  = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: if (sts.div_done) begin
        state_next = sts.pulse_go ? S_MULG : S_OUT;
      end
      S_MULG: begin
        cmd.mul_g  = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mul_t  = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.pulse_upd = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: if (!result_valid || out_ready) begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/edge_strength_update_core.sv
// edge strength update core: top level
// one item at a time: s_tready is high only in idle, once the previous result is loaded
// the 35-step age divider takes the largest share of each item's time in the core
// a result waiting on m_tready holds the following item at its result stage
// rst (synchronous, active high) loads the default rates and the initial edge state
module edge_strength_update_core import esu_pkg::*; #(
  parameter int NODE_BITS = NODE_BITS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // node_id, signal_value, tick
  input  logic [OP_W-1:0]       s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // strength, significance, decayed_activation, zero pad
  output logic                  m_tuser,   // accepted
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STR_W-1:0]      cfg_wdata
);

  esu_cmd_t cmd;
  esu_sts_t sts;

  esu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esu_datapath #(
    .NODE_BITS (NODE_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (s_tdata),
    .in_op        (s_tuser),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_accepted (m_tuser),
    .out_data     (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_strength_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STR_W-1:0] <= ONE_Q16))
    else $error("strength above one");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result beat without an item in work");
`endif

endmodule

FILE: tb/esu_checker.sv
// checker for the edge strength core: mirrors the edge state, predicts each result, compares
`timescale 1ns / 100ps

module esu_checker import esu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // node_id, signal_value, tick
  input  logic [OP_W-1:0]       s_tuser,   // operation
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // strength, significance, decayed_activation, zero pad
  input  logic                  m_tuser,   // accepted
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STR_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic                        accepted;
    logic [STR_W-1:0]            strength;
    logic signed [FIELD_W-1:0]   significance;
    logic signed [FIELD_W-1:0]   decayed;
  } edge_result_t;

  logic [STR_W-1:0]          rate_reg [4];
  logic [FIELD_W-1:0]        head_node;
  logic [STR_W-1:0]          edge_str;
  logic signed [FIELD_W-1:0] change_lvl;
  logic signed [FIELD_W-1:0] act_lvl;
  logic [FIELD_W-1:0]        last_tick;
  edge_result_t              edge_results_q [$];
  int                        fail_count = 0;

  function automatic longint eff_rate(input logic [CFG_IDX_W-1:0] idx);
    return (rate_reg[idx] > ONE_Q16) ? 65536 : longint'(rate_reg[idx]);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // age is one plus the wrapped tick distance
  function automatic longint age_div(input longint num, input logic [FIELD_W-1:0] span);
    return num / (longint'(span) + 1);
  endfunction

  function automatic void clear_edge();
    head_node  = '0;
    edge_str   = STR_W'(eff_rate(CFG_INIT_STR));
    change_lvl = '0;
    act_lvl    = '0;
    last_tick  = '0;
  endfunction

  function automatic edge_result_t step_edge(input logic [OP_W-1:0] op,
                                             input logic [FIELD_W-1:0] node,
                                             input logic signed [FIELD_W-1:0] sig,
                                             input logic [FIELD_W-1:0] tk);
    edge_result_t       r;
    longint             str_l, d, g, term, dv;
    logic [FIELD_W-1:0] span;
    r.accepted = 1'b0;
    str_l = longint'(edge_str);
    case (op)
      OP_QUERY: begin
        if (node == head_node) begin
          str_l = str_l + (((65536 - str_l) * eff_rate(CFG_MATCH_RATE)) >> 16);
          r.accepted = 1'b1;
        end else begin
          str_l = str_l - ((str_l * eff_rate(CFG_MISS_RATE)) >> 16);
          head_node = node;
        end
        edge_str = str_l[STR_W-1:0];
      end
      OP_PULSE: begin
        if (tk != last_tick) begin
          d    = age_div(longint'(change_lvl), tk - last_tick);
          g    = (longint'(sig) * str_l) / 65536;
          term = ((65536 - d) * g) / 65536;
          change_lvl = clamp_s32(d + term);
          str_l = str_l + (((65536 - str_l) * eff_rate(CFG_PULSE_RATE)) >> 16);
          edge_str   = str_l[STR_W-1:0];
          last_tick  = tk;
          r.accepted = 1'b1;
        end
      end
      OP_SET_ACT: begin
        dv = longint'(sig) - longint'(act_lvl);
        if (dv < 0) dv = -dv;
        change_lvl = clamp_s32(dv);
        act_lvl    = sig;
        last_tick  = tk;
      end
      OP_CLEAR: begin
        clear_edge();
      end
    endcase
    span = tk - last_tick;
    r.strength     = edge_str;
    r.significance = clamp_s32(age_div(longint'(change_lvl), span));
    r.decayed      = clamp_s32(age_div(longint'(act_lvl) * 10, span));
    return r;
  endfunction

  function automatic void note_failure(input string what, input edge_result_t want,
                                       input edge_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected acc=%0d str=%0d sig=%0d dec=%0d, %s",
               $realtime, what, want.accepted, want.strength, want.significance, want.decayed,
               $sformatf("got acc=%0d str=%0d sig=%0d dec=%0d",
                         got.accepted, got.strength, got.significance, got.decayed));
  endfunction

  always @(posedge clk) begin
    edge_result_t got, want;
    if (rst) begin
      rate_reg[CFG_MATCH_RATE] = MATCH_RATE_RST;
      rate_reg[CFG_MISS_RATE]  = MISS_RATE_RST;
      rate_reg[CFG_PULSE_RATE] = PULSE_RATE_RST;
      rate_reg[CFG_INIT_STR]   = INIT_STR_RST;
      clear_edge();
      edge_results_q.delete();
    end else begin
      if (cfg_wen) rate_reg[cfg_index] = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.accepted     = m_tuser;
        got.strength     = m_tdata[STR_W-1:0];
        got.significance = m_tdata[STR_W +: FIELD_W];
        got.decayed      = m_tdata[STR_W+FIELD_W +: FIELD_W];
        if (edge_results_q.size() == 0) begin
          note_failure("unexpected beat", '0, got);
        end else begin
          want = edge_results_q.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready)
        edge_results_q.push_back(step_edge(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                           s_tdata[95:64]));
    end
    pending <= edge_results_q.size();
    errors  <= fail_count;
  end

endmodule

FILE: tb/tb_top.sv
// top of the edge strength core testbench: clock, reset, stimulus, config phases and verdict
`timescale 1ns / 100ps

module tb_top import esu_pkg::*; ();

  localparam int SEG_ITEMS   = 230;
  localparam int HOLD_CYCLES = 600;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // node_id, signal_value, tick
  logic [OP_W-1:0]       s_tuser;   // operation
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // strength, significance, decayed_activation, zero pad
  logic                  m_tuser;   // accepted
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [STR_W-1:0]      cfg_wdata;
  int                    errors;
  int                    pending;

  int                    src_idle_pct  = 6;
  int                    sink_idle_pct = 75;
  int                    stall_armed   = 0;
  int                    stall_seen    = 0;
  logic [FIELD_W-1:0]    cur_tick      = '0;

  edge_strength_update_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  esu_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL edge_strength_update_core");
    $finish;
  end

  // result side: random backpressure plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_armed != stall_seen) begin
        stall_seen = stall_armed;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] node,
                           input logic [FIELD_W-1:0] sig, input logic [FIELD_W-1:0] tk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tk, sig, node};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] node, sig;
    int                 pick;
    pick = $urandom_range(99);
    op = (pick < 36) ? OP_QUERY : (pick < 72) ? OP_PULSE : (pick < 94) ? OP_SET_ACT : OP_CLEAR;
    pick = $urandom_range(99);
    if (pick < 80) node = $urandom_range(3);
    else if (pick < 85) node = '1;
    else node = $urandom();
    pick = $urandom_range(99);
    if (pick < 55) cur_tick += $urandom_range(1, 6);
    else if (pick >= 75 && pick < 85) cur_tick -= $urandom_range(1, 4);
    else if (pick >= 85) cur_tick = $urandom();
    pick = $urandom_range(99);
    if (pick < 40) begin
      sig = 32'($urandom_range(262143)) - 32'd131072;
    end else if (pick < 55) begin
      case ($urandom_range(4))
        0: sig = 32'h7FFF_FFFF;
        1: sig = 32'h8000_0000;
        2: sig = 32'h0001_0000;
        3: sig = 32'hFFFF_0000;
        default: sig = '0;
      endcase
    end else if (pick < 75) begin
      sig = 32'($urandom_range(33554431)) - 32'd16777216;
    end else begin
      sig = $urandom();
    end
    send_item(op, node, sig, cur_tick);
  endtask

  task automatic write_rates(input logic [STR_W-1:0] match_r, input logic [STR_W-1:0] miss_r,
                             input logic [STR_W-1:0] pulse_r, input logic [STR_W-1:0] init_s);
    logic [STR_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idx [4];
    vals = '{match_r, miss_r, pulse_r, init_s};
    idx  = '{CFG_MATCH_RATE, CFG_MISS_RATE, CFG_PULSE_RATE, CFG_INIT_STR};
    cfg_wen <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_QUERY;
    cfg_wen   <= 1'b0;
    cfg_index <= CFG_MATCH_RATE;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default rates, null head, repeated and wrapped ticks, saturation, clear
    send_item(OP_QUERY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_QUERY,   32'h0000_0005, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_QUERY,   32'h0000_0005, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PULSE,   32'h0000_0005, 32'h0001_0000, 32'h0000_0000);
    send_item(OP_PULSE,   32'h0000_0005, 32'h0001_0000, 32'h0000_000A);
    send_item(OP_PULSE,   32'h0000_0005, 32'h0001_0000, 32'h0000_000A);
    send_item(OP_SET_ACT, 32'h0000_0005, 32'h7FFF_FFFF, 32'h0000_000C);
    send_item(OP_QUERY,   32'h0000_0005, 32'h0000_0000, 32'h0000_000C);
    send_item(OP_SET_ACT, 32'h0000_0005, 32'h8000_0000, 32'h0000_000D);
    send_item(OP_QUERY,   32'h0000_0005, 32'h0000_0000, 32'h0000_000D);
    send_item(OP_PULSE,   32'h0000_0005, 32'h7FFF_FFFF, 32'h0000_0014);
    send_item(OP_PULSE,   32'h0000_0005, 32'h8000_0000, 32'h0000_0015);
    send_item(OP_QUERY,   32'h0000_0005, 32'h0000_0000, 32'h0000_0005);
    send_item(OP_PULSE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PULSE,   32'h0000_0005, 32'h0000_0000, 32'h0000_0003);
    send_item(OP_SET_ACT, 32'h0000_0005, 32'hFFFF_0000, 32'hFFFF_FFF0);
    send_item(OP_QUERY,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_QUERY,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_CLEAR,   32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    send_item(OP_QUERY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_QUERY,   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_SET_ACT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_CLEAR,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: write_rates(17'd0, 17'd0, 17'd0, 17'd0);
        1: write_rates(17'd65536, 17'd65536, 17'd65536, 17'd65536);
        2: write_rates(17'd131071, 17'd65537, 17'd99999, 17'd131071);
        3: write_rates(17'($urandom_range(65536)), 17'($urandom_range(65536)),
                       17'($urandom_range(65536)), 17'($urandom_range(65536)));
        4: write_rates(17'($urandom()), 17'($urandom()), 17'($urandom()), 17'($urandom()));
        default: write_rates(MATCH_RATE_RST, MISS_RATE_RST, PULSE_RATE_RST, INIT_STR_RST);
      endcase
      src_idle_pct  = (seg < 2) ? 6 : (seg < 4) ? 75 : 0;
      sink_idle_pct = (seg < 2) ? 75 : (seg < 4) ? 6 : 0;
      // long hold-off on the result side while items keep coming
      if (seg == 4) stall_armed++;
      for (int n = 0; n < SEG_ITEMS; n++) send_random();
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS edge_strength_update_core");
    else
      $display("FAIL edge_strength_update_core");
    $finish;
  end

endmodule
